// File: rtl/obt_pkg.sv
// Shared types and constants for the order book table.
// Holds the slot record, the slot write request and the command codes.
// Depends on nothing; the top level and the slot store refer to it by scoped names, the sim files import it.
package obt_pkg;

    localparam int ID_W    = 32;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 4;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEC  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // One resting order as stored in a slot.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } slot_t;

    // Write request from the control logic to the slot store.
    typedef struct packed {
        logic  en;
        slot_t entry;
    } slot_wr_t;

endpackage

// File: rtl/order_book_table.sv
// Top level of the order book table: request handshake, scan sequencer,
// best price and fill pointer, and the result register.
// Depends on obt_pkg and instantiates obt_slot_store.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_tvalid / s_tready  s_tuser command, s_tdata book/key/price/qty
//   m_       out        m_tvalid / m_tready  m_tdata best price and entry count
//
// Add, no operation and requests for another book go from acceptance straight to
// the result state. Decrease and delete first scan every slot in the scan state;
// delete also spends a scan step on each matching slot that it removes. The scan is
// paced by the single read port of the slot store, one slot a cycle.
// Reset clears the pointer, the best price, the result valid flag and the slot
// valid bits at once; there is no clearing pass.
// A result that is not taken holds the block before it loads the next one, but
// a new request is still accepted while the previous result waits.
module order_book_table #(
    parameter int SLOTS = 15
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] book_id, [63:32] order_key, [95:64] order_price, [127:96] order_quantity
    input  logic [127:0] s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] best_price, [35:32] entry_count, [39:36] zero
    output logic [39:0]  m_tdata
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(SLOTS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [31:0]            key_reg, key_next;
    logic [31:0]            qty_reg, qty_next;
    logic [PW-1:0]          fill_reg, fill_next;
    logic signed [31:0]     top_reg, top_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [PW-1:0]          wr_pos_reg, wr_pos_next;
    logic                   skip_reg, skip_next;
    logic                   data_ok_reg, data_ok_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [31:0]     m_price_reg, m_price_next;
    logic [3:0]             m_count_reg, m_count_next;

    logic                   accept;
    logic [1:0]             in_cmd;
    logic [31:0]            in_book;
    logic [31:0]            in_key;
    logic signed [31:0]     in_price;
    logic [31:0]            in_qty;
    logic                   hit;
    obt_pkg::slot_t         rd_entry;
    obt_pkg::slot_wr_t      wr_req;
    logic [AW-1:0]          wr_addr;

    assign in_cmd   = s_tuser;
    assign in_book  = s_tdata[31:0];
    assign in_key   = s_tdata[63:32];
    assign in_price = signed'(s_tdata[95:64]);
    assign in_qty   = s_tdata[127:96];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign hit      = (rd_entry.id == key_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_count_reg, m_price_reg};

    obt_slot_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_entry),
        .wr_req  (wr_req),
        .wr_addr (wr_addr)
    );

    // The delete scan streams the slots out of the store in order, one per cycle,
    // and writes the surviving sequence back starting at slot 0. After a match the
    // following slot is written without being compared, since the shifted copy
    // is never examined again. Once the read address reaches the last slot it
    // stays there, which reproduces the repeated copies of the last slot that the
    // shifting leaves behind. The write position never passes the read address,
    // so nothing is overwritten before it is read.
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        qty_next     = qty_reg;
        fill_next    = fill_reg;
        top_next     = top_reg;
        rd_addr_next = rd_addr_reg;
        wr_pos_next  = wr_pos_reg;
        skip_next    = skip_reg;
        data_ok_next = data_ok_reg;
        m_price_next = m_price_reg;
        m_count_next = m_count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        wr_req       = '0;
        wr_addr      = '0;

        case (state_reg)
            ST_IDLE: begin
                rd_addr_next = '0;
                wr_pos_next  = '0;
                skip_next    = 1'b0;
                data_ok_next = 1'b0;
                if (accept) begin
                    cmd_next   = in_cmd;
                    key_next   = in_key;
                    qty_next   = in_qty;
                    state_next = ST_RESULT;
                    if (in_book == 32'd0) begin
                        case (in_cmd)
                            obt_pkg::CMD_ADD: begin
                                // The pointer is always below SLOTS here.
                                wr_req.en          = 1'b1;
                                wr_req.entry.id    = in_key;
                                wr_req.entry.price = in_price;
                                wr_req.entry.qty   = in_qty;
                                wr_addr            = fill_reg[AW-1:0];
                                fill_next = (fill_reg == LAST_POS) ? '0 : fill_reg + 1'b1;
                                if (in_price > top_reg) begin
                                    top_next = in_price;
                                end
                            end
                            obt_pkg::CMD_DEL, obt_pkg::CMD_DEC: begin
                                state_next = ST_SCAN;
                            end
                            default: begin
                                state_next = ST_RESULT;
                            end
                        endcase
                    end
                end
            end

            ST_SCAN: begin
                data_ok_next = 1'b1;
                if (rd_addr_reg != LAST_ADDR) begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                if (data_ok_reg) begin
                    if (cmd_reg == obt_pkg::CMD_DEL && !skip_reg && hit) begin
                        // Drop this slot; the next one fills its place unexamined.
                        skip_next = 1'b1;
                        if (fill_reg != '0) begin
                            fill_next = fill_reg - 1'b1;
                        end
                    end else begin
                        skip_next    = 1'b0;
                        wr_req.en    = 1'b1;
                        wr_req.entry = rd_entry;
                        wr_addr      = wr_pos_reg[AW-1:0];
                        if (cmd_reg == obt_pkg::CMD_DEC && hit) begin
                            wr_req.entry.qty = rd_entry.qty - qty_reg;
                        end
                        wr_pos_next = wr_pos_reg + 1'b1;
                        if (wr_pos_reg == LAST_POS) begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_price_next = top_reg;
                    m_count_next = 4'(fill_reg);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            top_reg     <= '0;
            rd_addr_reg <= '0;
            wr_pos_reg  <= '0;
            skip_reg    <= 1'b0;
            data_ok_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            top_reg     <= top_next;
            rd_addr_reg <= rd_addr_next;
            wr_pos_reg  <= wr_pos_next;
            skip_reg    <= skip_next;
            data_ok_reg <= data_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        qty_reg     <= qty_next;
        m_price_reg <= m_price_next;
        m_count_reg <= m_count_next;
    end

endmodule

// File: rtl/obt_slot_store.sv
// Slot store of the order book table: one synchronous memory of slot records.
// One write port and one read port with the read data registered.
// Depends on obt_pkg for the slot record and the write request.
module obt_slot_store #(
    parameter int SLOTS = 15
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output obt_pkg::slot_t         rd_data,
    input  obt_pkg::slot_wr_t      wr_req,
    input  logic [$clog2(SLOTS)-1:0] wr_addr
);

    obt_pkg::slot_t          mem [SLOTS];
    logic [SLOTS-1:0]        valid_reg;
    obt_pkg::slot_t          rd_q_reg;
    logic                    rd_vld_reg;

    // Entries never written since reset read as all zero.
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_addr] <= wr_req.entry;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_req.en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

// File: rtl/obt_checker.sv
// Port-level checks for the order book table, attached by the bind below.
// Watches only the top level's ports; depends on nothing else.
module obt_checker #(
    parameter int SLOTS = 15
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    // A request is worked on alone: the block is busy right after it accepts one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while the previous one is still in work");

    // A stalled result stays and keeps its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // The fill pointer stays below the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (SLOTS > 16) || (int'(m_tdata[35:32]) < SLOTS))
        else $error("entry count beyond the table size");

    // A new result is loaded only at the end of a request, never while idle.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a request in work");

endmodule

bind order_book_table obt_checker #(.SLOTS(SLOTS)) u_obt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/order_book_check_pkg.sv
// Scoreboard for the order book table testbench: a behavioral copy of the slot
// table, the best price and the fill pointer, plus the queue of predicted results.
// Depends on obt_pkg for the command codes, field widths and the slot record.
package order_book_check_pkg;

    import obt_pkg::*;

    localparam int TABLE_SLOTS = 15;

    typedef struct packed {
        logic [PRICE_W-1:0] best_price;
        logic [COUNT_W-1:0] entry_count;
    } quote_t;

    class book_scoreboard;

        slot_t              slots[TABLE_SLOTS];
        int                 fill;
        logic [PRICE_W-1:0] top_price;
        quote_t             expected_quotes[$];
        int unsigned        failures;

        function new();
            foreach (slots[i]) slots[i] = '0;
            fill      = 0;
            top_price = '0;
            failures  = 0;
        endfunction

        // Applies one accepted request to the table copy and queues the quote it yields.
        function void note_request(input logic [CMD_W-1:0] cmd, input logic [31:0] book,
                                   input logic [31:0] key, input logic [31:0] price,
                                   input logic [31:0] qty);
            quote_t q;
            if (book == '0) begin
                case (cmd)
                    CMD_ADD: begin
                        slots[fill].id    = key;
                        slots[fill].price = price;
                        slots[fill].qty   = qty;
                        fill++;
                        if (fill >= TABLE_SLOTS) fill = 0;
                        if ($signed(price) > $signed(top_price)) top_price = price;
                    end
                    CMD_DEL: begin
                        // The slot shifted into a removed place is not examined again.
                        for (int i = 0; i < TABLE_SLOTS; i++) begin
                            if (slots[i].id == key) begin
                                for (int j = i; j < TABLE_SLOTS - 1; j++) slots[j] = slots[j + 1];
                                if (fill > 0) fill--;
                            end
                        end
                    end
                    CMD_DEC: begin
                        foreach (slots[i]) begin
                            if (slots[i].id == key) slots[i].qty = slots[i].qty - qty;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            q.best_price  = top_price;
            q.entry_count = 4'(fill);
            expected_quotes.push_back(q);
        endfunction

        // Compares one accepted result with the oldest predicted quote.
        function void check_quote(input logic [39:0] data, input time stamp);
            quote_t want;
            if (expected_quotes.size() == 0) begin
                $display("%0t: result with no request outstanding, actual best_price %0d count %0d",
                         stamp, $signed(data[31:0]), data[35:32]);
                failures++;
                return;
            end
            want = expected_quotes.pop_front();
            if (data[31:0] !== want.best_price) begin
                $display("%0t: best_price expected %0d actual %0d", stamp,
                         $signed(want.best_price), $signed(data[31:0]));
                failures++;
            end
            if (data[35:32] !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d", stamp,
                         want.entry_count, data[35:32]);
                failures++;
            end
            if (data[39:36] !== 4'd0) begin
                $display("%0t: result padding expected 0 actual %h", stamp, data[39:36]);
                failures++;
            end
        endfunction

    endclass

endpackage

// File: sim/tb_order_book_table.sv
// Testbench for order_book_table: drives add, delete, decrease and no-op requests
// with random gaps and result back-pressure, and checks every result against a model.
// Depends on obt_pkg and order_book_check_pkg.
module tb_order_book_table;

    timeunit 1ns;
    timeprecision 1ps;

    import obt_pkg::*;
    import order_book_check_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int DRAIN_CYCLES    = 40;   // a bit more than the slowest delete

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = CMD_NOP;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    book_scoreboard book_model = new();

    // Requests left in the current sender burst; a gap may come when it runs out.
    int burst_left = 0;

    // Receiver stall pattern: a mode held for a random stretch of cycles.
    int ready_mode  = 0;
    int ready_left  = 0;
    int ready_phase = 0;

    order_book_table #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Inputs move on the falling edge so the rising edge always sees settled values.
    // The receiver switches between always ready, mostly ready, mostly stalled and a
    // fixed pattern that is ready only when its phase counter wraps to zero.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end else begin
            ready_left--;
        end
        ready_phase = (ready_phase + 1) % 7;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_phase == 0);
        endcase
    end

    // Every result taken by the receiver is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book_model.check_quote(m_tdata, $time);
    end

    // Sends one request. When a burst ends the sender may first drop valid and idle.
    // Called on a falling edge and returns on the falling edge after acceptance.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [31:0] book,
                         input logic [31:0] key, input logic [31:0] price,
                         input logic [31:0] qty);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {qty, price, key, book};
        do @(posedge aclk); while (!s_tready);
        book_model.note_request(cmd, book, key, price, qty);
        @(negedge aclk);
    endtask

    // Holds the sender off until every outstanding request has produced its result.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (book_model.expected_quotes.size() != 0) @(negedge aclk);
    endtask

    // Keys come mostly from a small pool so deletes and decreases find matches,
    // including duplicates; zero hits the empty slots.
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 32'd0;
        if (roll < 78) return 32'($urandom_range(1, 6));
        if (roll < 85) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_book();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 88) return 32'd0;
        if (roll < 93) return $urandom;
        if (roll < 97) return 32'd1 << $urandom_range(0, 31);
        return 32'hFFFF_FFFF;
    endfunction

    // Prices drift upward over the run so the best price keeps moving; the occasional
    // full-width negative value exercises the upper bits without pinning the best price.
    function automatic logic [31:0] pick_price(input int step);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return {1'b1, 31'($urandom)};
        return 32'(step * 40 + int'($urandom_range(0, 4000)) - 2000);
    endfunction

    function automatic logic [31:0] pick_qty();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 32'd0;
        if (roll == 1) return 32'hFFFF_FFFF;
        if (roll < 6) return 32'($urandom_range(1, 100));
        return $urandom;
    endfunction

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [31:0]      book;
        int               acted;
        int               step;
        int               roll;
        int               add_share;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests: no-ops, field extremes, other books, wrapping decreases,
        // delete of adjacent duplicates and of empty slots with the count saturating.
        issue(CMD_NOP, 32'd0, 32'd0, 32'd0, 32'd0);
        issue(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(CMD_ADD, 32'd0, 32'd7, 32'd100, 32'd10);
        issue(CMD_ADD, 32'd0, 32'd7, 32'd50, 32'hFFFF_FFFF);
        issue(CMD_ADD, 32'd0, 32'd7, 32'd300, 32'd0);
        issue(CMD_ADD, 32'd0, 32'd9, 32'h8000_0000, 32'd1);
        issue(CMD_ADD, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5);
        issue(CMD_ADD, 32'd1, 32'd7, 32'h7FFF_FFFF, 32'd3);
        issue(CMD_DEL, 32'h8000_0000, 32'd7, 32'd0, 32'd0);
        issue(CMD_DEC, 32'd0, 32'd7, 32'd0, 32'd3);
        issue(CMD_DEC, 32'd0, 32'd9, 32'd0, 32'hFFFF_FFFF);
        issue(CMD_DEC, 32'd0, 32'd12345, 32'd0, 32'd1);
        // Three copies of key 7 in a row: only two of them go, one stays at slot 0.
        issue(CMD_DEL, 32'd0, 32'd7, 32'd0, 32'd0);
        issue(CMD_DEL, 32'd0, 32'd7, 32'd0, 32'd0);
        issue(CMD_DEL, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        // Key zero matches every empty slot, so the count would go below zero.
        issue(CMD_DEL, 32'd0, 32'd0, 32'd0, 32'd0);
        issue(CMD_DEC, 32'd0, 32'd0, 32'd0, 32'd1);
        issue(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
        issue(CMD_ADD, 32'd0, 32'd0, 32'd1000, 32'd8);
        issue(CMD_DEL, 32'd0, 32'd9, 32'd0, 32'd0);
        issue(CMD_NOP, 32'd5, 32'd1, 32'd1, 32'd1);

        wait_for_results();

        // Random requests. The share of adds changes every hundred requests so the
        // table alternately fills up and wraps, then drains through deletes.
        acted     = 0;
        step      = 0;
        add_share = 50;
        while (acted < RANDOM_REQUESTS) begin
            if (step % 100 == 0) add_share = $urandom_range(25, 75);
            if (step % 500 == 250) wait_for_results();
            roll = $urandom_range(0, 99);
            if (roll < add_share) begin
                cmd = CMD_ADD;
            end else begin
                roll = $urandom_range(0, 9);
                cmd  = (roll < 5) ? CMD_DEL : (roll < 9) ? CMD_DEC : CMD_NOP;
            end
            book = pick_book();
            issue(cmd, book, pick_key(), pick_price(step), pick_qty());
            acted++;
            step++;
        end

        // The highest price goes in last so it does not freeze the best price earlier.
        issue(CMD_ADD, 32'd0, 32'd3, 32'h7FFF_FFFF, 32'd1);
        issue(CMD_ADD, 32'd0, 32'd3, 32'h8000_0000, 32'd2);
        issue(CMD_DEL, 32'd0, 32'd3, 32'd0, 32'd0);

        s_tvalid <= 1'b0;
        while (book_model.expected_quotes.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book_model.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hang: far longer than the slowest correct run needs.
    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
